[rtl/ffra_pkg.sv]
// Shared types and constants for the first-fit range allocator.
package ffra_pkg;
    localparam int RANGE_BYTES_DEF  = 67108864;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int OFS_W  = 26;
    localparam int SIZE_W = 27;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ROOM    = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode           op;
        logic [SIZE_W-1:0] size;
        logic [OFS_W-1:0]  offset;
        logic              zero_size;
    } t_cmd;
endpackage

[rtl/ffra_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
module ffra_front
    import ffra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SIZE_W+OFS_W:0] i_data,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output t_cmd                  o_cmd
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    t_cmd          w_cmd;
    logic          w_push, w_pop;

    always_comb begin
        w_cmd.op        = t_opcode'(i_data[0]);
        w_cmd.size      = i_data[SIZE_W:1];
        w_cmd.offset    = i_data[SIZE_W+OFS_W:SIZE_W+1];
        w_cmd.zero_size = (i_data[SIZE_W:1] == '0);
    end

    assign o_ready     = (r_cnt != (PW+1)'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end
endmodule

[rtl/ffra_back.sv]
// Back end: walks the segment table, inserts or removes entries, drives results.
module ffra_back
    import ffra_pkg::*;
#(
    parameter int RANGE_BYTES  = RANGE_BYTES_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    output logic                     o_cmd_ready,
    input  t_cmd                     i_cmd,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [OFS_W+SIZE_W+1:0]  o_data
);
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int PW = SIZE_W + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_WR    = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    logic [OFS_W-1:0]  r_start [MAX_SEGMENTS];
    logic [SIZE_W-1:0] r_len   [MAX_SEGMENTS];

    t_state            r_state;
    t_cmd              r_cmd;
    logic [CW-1:0]     r_count, r_idx, r_k;
    logic [SIZE_W-1:0] r_free;
    logic [PW-1:0]     r_pos;
    logic [OFS_W-1:0]  r_rs;
    logic [SIZE_W-1:0] r_rl;
    logic              r_dir;
    t_status           r_st;
    logic [OFS_W-1:0]  r_gr;
    logic [SIZE_W-1:0] r_bf;
    logic              r_sh_ph;

    logic [PW-1:0]     w_s, w_gap;
    logic              w_fit;
    logic [CW-1:0]     w_src;
    logic [IW-1:0]     w_ra;

    assign w_s   = PW'(r_rs);
    assign w_gap = w_s - r_pos;
    assign w_fit = (w_s >= r_pos) && (w_gap >= PW'(r_cmd.size));
    assign w_src = r_dir ? r_k + 1'b1 : r_k - 1'b1;
    assign w_ra  = (r_state == S_SHIFT) ? w_src[IW-1:0] :
                   (r_state == S_IDLE)  ? '0 : r_idx[IW-1:0];

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_data      = {r_bf, r_gr, r_st};

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE || r_state == S_RD || r_state == S_SHIFT) begin
            r_rs <= r_start[w_ra];
            r_rl <= r_len[w_ra];
        end
        if (r_state == S_SHIFT && r_sh_ph) begin
            r_start[r_k[IW-1:0]] <= r_rs;
            r_len[r_k[IW-1:0]]   <= r_rl;
        end else if (r_state == S_WR && !r_dir) begin
            r_start[r_idx[IW-1:0]] <= r_pos[OFS_W-1:0];
            r_len[r_idx[IW-1:0]]   <= r_cmd.size;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_free  <= SIZE_W'(RANGE_BYTES);
            r_idx   <= '0;
            r_sh_ph <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_pos <= '0;
                        r_gr  <= '0;
                        r_dir <= (i_cmd.op == OP_FREE);
                        if (i_cmd.op == OP_ALLOC &&
                            (i_cmd.zero_size || i_cmd.size > r_free)) begin
                            r_st <= ST_NO_ROOM; r_bf <= r_free; r_state <= S_OUT;
                        end else if (i_cmd.op == OP_ALLOC &&
                                     r_count >= CW'(MAX_SEGMENTS)) begin
                            r_st <= ST_TABLE_FULL; r_bf <= r_free; r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_idx == r_count) begin
                        if (r_dir) begin
                            r_st <= ST_NOT_FOUND; r_bf <= r_free; r_state <= S_OUT;
                        end else if (r_pos > PW'(RANGE_BYTES) ||
                                     PW'(r_cmd.size) > PW'(RANGE_BYTES) - r_pos) begin
                            r_st <= ST_NO_ROOM; r_bf <= r_free; r_state <= S_OUT;
                        end else begin
                            r_k <= r_count; r_sh_ph <= 1'b0; r_state <= S_WR;
                        end
                    end else if (r_dir ? (r_rs == r_cmd.offset) : w_fit) begin
                        if (r_dir) r_free <= r_free + r_rl;
                        r_k <= r_dir ? r_idx : r_count;
                        r_sh_ph <= 1'b0;
                        r_state <= S_SHIFT;
                    end else begin
                        r_pos   <= w_s + PW'(r_rl);
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_SHIFT: begin
                    if (!r_sh_ph) begin
                        if (r_dir ? (r_k + 1'b1 >= r_count) : (r_k == r_idx)) begin
                            r_state <= S_WR;
                        end else begin
                            r_sh_ph <= 1'b1;
                        end
                    end else begin
                        r_sh_ph <= 1'b0;
                        r_k <= w_src;
                    end
                end
                S_WR: begin
                    r_st <= ST_OK;
                    if (r_dir) begin
                        r_count <= r_count - 1'b1;
                        r_bf    <= r_free;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_free  <= r_free - r_cmd.size;
                        r_bf    <= r_free - r_cmd.size;
                        r_gr    <= r_pos[OFS_W-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/first_fit_range_allocator_unit.sv]
// Top level of the first-fit range allocator.
//  channel  | direction | tdata fields (low bit up)
//  s_axis   | in        | opcode[0], request_size[27:1], free_offset[53:28]
//  m_axis   | out       | status[1:0], granted_offset[27:2], bytes_free[54:28]
// Back end: scans the table from idle, passes over entries (a read each), moves entries
// in the shift state, writes and presents the result; an allocate at the tail skips the
// shift, and a failed request goes from the idle or scan state straight to the result.
// Reset clears the count and restores free bytes; table contents stay unset.
// A two-entry queue lets requests enter while the back end works or stalls.
module first_fit_range_allocator_unit
    import ffra_pkg::*;
#(
    parameter int RANGE_BYTES  = RANGE_BYTES_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // opcode, request_size, free_offset, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // status, granted_offset, bytes_free, pad
);
    logic                  w_cv, w_cr;
    t_cmd                  w_cmd;
    logic [OFS_W+SIZE_W+1:0] w_od;

    ffra_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata[SIZE_W+OFS_W:0]),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    ffra_back #(.RANGE_BYTES(RANGE_BYTES), .MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_od)
    );

    assign m_axis_tdata = {1'b0, w_od};
endmodule

[rtl/ffra_checker.sv]
// Port-level assertions for the first-fit range allocator.
module ffra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[27:2] == '0)
        else $error("offset on failed request");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[55] == 1'b0)
        else $error("pad bit set");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
    a_rdy: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");
endmodule

bind first_fit_range_allocator_unit ffra_checker u_ffra_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
